### design/acst_pkg.sv
// ----------------------------------------------------------------------------
// acst_pkg
// Types, codes and saturating Q16.16 helpers for the box side test.
// ----------------------------------------------------------------------------
package acst_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ENTITY = 1'd1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_TEST  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        SIDE_NONE   = 3'd0,
        SIDE_LEFT   = 3'd1,
        SIDE_RIGHT  = 3'd2,
        SIDE_TOP    = 3'd3,
        SIDE_BOTTOM = 3'd4
    } t_side;

    typedef struct packed {
        logic        [1:0]  operation;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] extent_neg_x;
        logic signed [31:0] extent_pos_x;
        logic signed [31:0] extent_neg_y;
        logic signed [31:0] extent_pos_y;
        logic        [63:0] other_layer;
        logic        [15:0] other_entity;
        logic        [15:0] other_id;
    } t_in_item;

    typedef struct packed {
        logic               colliding;
        logic        [15:0] partner_id;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic        [2:0]  side;
    } t_out_item;

    // Bounds of one box plus what the test stage needs
    typedef struct packed {
        logic        [1:0]  operation;
        logic               eligible;
        logic signed [31:0] min_x;
        logic signed [31:0] max_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_y;
        logic        [15:0] other_id;
    } t_stage;

    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v[47:31] == {17{1'b0}} || v[47:31] == {17{1'b1}}) begin
            r = v[31:0];
        end else if (v[47]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] == v[31]) begin
            r = v[31:0];
        end else if (v[32]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // Q16.16 product, floor, saturated
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return sat48(p[63:16]);
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        return sat33(s);
    endfunction

endpackage

### design/acst_bounds.sv
// ----------------------------------------------------------------------------
// acst_bounds
// First stage: scales the extents, forms the box bounds and the layer and
// entity filter, and registers them.
// ----------------------------------------------------------------------------
module acst_bounds (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  acst_pkg::t_in_item i_item,
    input  logic [63:0]       i_target_mask,
    input  logic [15:0]       i_self_entity,
    output logic              o_valid,
    input  logic              i_ready,
    output acst_pkg::t_stage  o_stage
);
    import acst_pkg::*;

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_stage.operation = i_item.operation;
        n_stage.eligible  = ((i_target_mask & i_item.other_layer) != 64'd0) &&
                            (i_self_entity != i_item.other_entity);
        n_stage.min_x     = sat_sub(i_item.pos_x, qmul(i_item.scale_x, i_item.extent_neg_x));
        n_stage.max_x     = sat_add(i_item.pos_x, qmul(i_item.scale_x, i_item.extent_pos_x));
        n_stage.min_y     = sat_sub(i_item.pos_y, qmul(i_item.scale_y, i_item.extent_neg_y));
        n_stage.max_y     = sat_add(i_item.pos_y, qmul(i_item.scale_y, i_item.extent_pos_y));
        n_stage.other_id  = i_item.other_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

### design/acst_test.sv
// ----------------------------------------------------------------------------
// acst_test
// Second stage: holds the own box and the collision record, runs the overlap
// and side test and registers the result.
// ----------------------------------------------------------------------------
module acst_test (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  acst_pkg::t_stage   i_stage,
    output logic               o_valid,
    input  logic               i_ready,
    output acst_pkg::t_out_item o_item
);
    import acst_pkg::*;

    logic signed [31:0] r_own_min_x, r_own_max_x, r_own_min_y, r_own_max_y;
    logic signed [31:0] n_own_min_x, n_own_max_x, n_own_min_y, n_own_max_y;
    logic               r_hit_flag, n_hit_flag;
    logic        [15:0] r_hit_partner, n_hit_partner;
    logic signed [31:0] r_hit_point_x, n_hit_point_x;
    logic signed [31:0] r_hit_point_y, n_hit_point_y;
    t_side              r_hit_side, n_hit_side;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               adv;
    logic               overlap;
    logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [32:0] sum_x, sum_y;
    logic signed [31:0] d_l, d_r, d_t, d_b;
    t_side              side_sel;

    assign o_ready = !r_out_valid || i_ready;
    assign adv     = i_valid && o_ready;

    always_comb begin
        overlap = (r_own_min_x <= i_stage.max_x) && (r_own_max_x >= i_stage.min_x) &&
                  (r_own_min_y <= i_stage.max_y) && (r_own_max_y >= i_stage.min_y);
        lo_x  = (r_own_min_x > i_stage.min_x) ? r_own_min_x : i_stage.min_x;
        hi_x  = (r_own_max_x < i_stage.max_x) ? r_own_max_x : i_stage.max_x;
        lo_y  = (r_own_min_y > i_stage.min_y) ? r_own_min_y : i_stage.min_y;
        hi_y  = (r_own_max_y < i_stage.max_y) ? r_own_max_y : i_stage.max_y;
        sum_x = {lo_x[31], lo_x} + {hi_x[31], hi_x};
        sum_y = {lo_y[31], lo_y} + {hi_y[31], hi_y};
        d_l   = sat_sub(i_stage.max_x, r_own_min_x);
        d_r   = sat_sub(r_own_max_x, i_stage.min_x);
        d_t   = sat_sub(i_stage.max_y, r_own_min_y);
        d_b   = sat_sub(r_own_max_y, i_stage.min_y);
        if (d_l <= d_r && d_l <= d_t && d_l <= d_b) begin
            side_sel = SIDE_LEFT;
        end else if (d_r <= d_t && d_r <= d_b) begin
            side_sel = SIDE_RIGHT;
        end else if (d_t <= d_b) begin
            side_sel = SIDE_TOP;
        end else begin
            side_sel = SIDE_BOTTOM;
        end
    end

    always_comb begin
        n_own_min_x   = r_own_min_x;
        n_own_max_x   = r_own_max_x;
        n_own_min_y   = r_own_min_y;
        n_own_max_y   = r_own_max_y;
        n_hit_flag    = r_hit_flag;
        n_hit_partner = r_hit_partner;
        n_hit_point_x = r_hit_point_x;
        n_hit_point_y = r_hit_point_y;
        n_hit_side    = r_hit_side;
        case (t_op'(i_stage.operation))
            OP_CLEAR: begin
                n_hit_flag = 1'b0;
            end
            OP_LOAD: begin
                n_own_min_x = i_stage.min_x;
                n_own_max_x = i_stage.max_x;
                n_own_min_y = i_stage.min_y;
                n_own_max_y = i_stage.max_y;
            end
            OP_TEST: begin
                if (i_stage.eligible) begin
                    if (overlap) begin
                        n_hit_flag    = 1'b1;
                        n_hit_partner = i_stage.other_id;
                        n_hit_point_x = sum_x[32:1];
                        n_hit_point_y = sum_y[32:1];
                        n_hit_side    = side_sel;
                    end else if (!r_hit_flag) begin
                        n_hit_partner = 16'd0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_min_x   <= '0;
            r_own_max_x   <= '0;
            r_own_min_y   <= '0;
            r_own_max_y   <= '0;
            r_hit_flag    <= 1'b0;
            r_hit_partner <= '0;
            r_hit_point_x <= '0;
            r_hit_point_y <= '0;
            r_hit_side    <= SIDE_NONE;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (adv) begin
                r_own_min_x   <= n_own_min_x;
                r_own_max_x   <= n_own_max_x;
                r_own_min_y   <= n_own_min_y;
                r_own_max_y   <= n_own_max_y;
                r_hit_flag    <= n_hit_flag;
                r_hit_partner <= n_hit_partner;
                r_hit_point_x <= n_hit_point_x;
                r_hit_point_y <= n_hit_point_y;
                r_hit_side    <= n_hit_side;
            end
        end
        if (adv) begin
            r_out_item.colliding  <= n_hit_flag;
            r_out_item.partner_id <= n_hit_partner;
            r_out_item.point_x    <= n_hit_point_x;
            r_out_item.point_y    <= n_hit_point_y;
            r_out_item.side       <= 3'(n_hit_side);
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    a_flag_has_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit_flag |-> r_hit_side != SIDE_NONE)
        else $error("colliding without a contact side");

    a_clear_drops_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && i_stage.operation == OP_CLEAR) |=> !r_hit_flag)
        else $error("clear did not drop the colliding flag");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_hit_flag) && $stable(r_hit_partner) && $stable(r_own_min_x))
        else $error("state changed without a transfer");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(adv) |-> o_item.colliding == r_hit_flag && o_item.partner_id == r_hit_partner)
        else $error("result does not match the recorded state");

endmodule

### design/aabb_collision_side_test.sv
// ----------------------------------------------------------------------------
// aabb_collision_side_test
// Tests one 2D box against a stream of other boxes and reports the partner,
// intersection centre and contact side.
//
//   channel   signals                                   direction
//   in        i_in_valid  / o_in_ready  / i_in_item     item in
//   out       o_out_valid / i_out_ready / o_out_item    result out
//   cfg       i_cfg_valid / o_cfg_ready / i_cfg_index, i_cfg_data  write in
//
// One item per cycle while the output is not stalled; each result is registered
// first in the bounds stage with the four multipliers, then in the test stage.
// Reset clears the record, the own box and both config registers.
// A stalled output holds both stages; ready propagates back combinationally.
// ----------------------------------------------------------------------------
module aabb_collision_side_test (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  acst_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output acst_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [acst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [acst_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import acst_pkg::*;

    logic [63:0] r_target_mask;
    logic [15:0] r_self_entity;
    logic        mid_valid;
    logic        mid_ready;
    t_stage      mid_stage;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_mask <= '0;
            r_self_entity <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TARGET_MASK: r_target_mask <= i_cfg_data;
                CFG_SELF_ENTITY: r_self_entity <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    acst_bounds u_bounds (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_item        (i_in_item),
        .i_target_mask (r_target_mask),
        .i_self_entity (r_self_entity),
        .o_valid       (mid_valid),
        .i_ready       (mid_ready),
        .o_stage       (mid_stage)
    );

    acst_test u_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_stage (mid_stage),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule
